### hdl/pnts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pnts_pkg: shared types and constants of the priority nearest top-k selector
// Slot count, field widths, register indexes, queue entry and slot types, and
// the ranking function used by the replacement and the flush ordering.
// ----------------------------------------------------------------------------
package pnts_pkg;

  // slot storage size and derived index widths
  localparam int MAX_SLOTS = 16;
  localparam int SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int COUNT_W   = $clog2(MAX_SLOTS + 1);

  // field widths
  localparam int COORD_W = 21;
  localparam int MAG_W   = 21;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int DIST_W  = SQ_W + 1;
  localparam int LIMIT_W = 7;

  // stream widths
  localparam int S_TDATA_W = 64;
  localparam int M_TDATA_W = 112;

  // decoupling queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration register indexes
  localparam logic [1:0] REG_CENTER_X = 2'd0;
  localparam logic [1:0] REG_CENTER_Z = 2'd1;
  localparam logic [1:0] REG_MAX_KEPT = 2'd2;

  // command codes
  localparam logic CMD_OFFER = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // reset value of the limit register
  localparam logic [LIMIT_W-1:0] MAX_KEPT_RESET = 7'd16;

  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_z;
    logic [LIMIT_W-1:0]        max_kept;
  } cfg_t;

  typedef struct packed {
    logic                      cmd;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      urgent;
    logic [DIST_W-1:0]         sq_dist;
  } item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      urgent;
    logic [DIST_W-1:0]         sq_dist;
  } slot_t;

  // queue status toward the back end
  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

  // true if entry a ranks strictly ahead of entry b
  function automatic logic rank_before(input logic ua, input logic [DIST_W-1:0] da,
                                       input logic ub, input logic [DIST_W-1:0] db);
    logic r;
    if (ua != ub) begin
      r = ua;
    end else begin
      r = (da < db);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### hdl/pnts_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pnts_front: input stage and distance pipeline
// Accepts stream items, forms |dx| and |dz| against the centre, squares them
// in a registered stage and pushes the item with its distance into the queue.
// ----------------------------------------------------------------------------
module pnts_front (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire pnts_pkg::cfg_t                    cfg,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // s_tdata fields from bit 0: pos_x, pos_y, pos_z, urgent
  input  wire logic [pnts_pkg::S_TDATA_W-1:0]    s_tdata,
  // s_tuser fields from bit 0: cmd
  input  wire logic                              s_tuser,
  input  wire pnts_pkg::q_stat_t                 q_stat,
  output logic                                   q_push,
  output pnts_pkg::item_t                        q_data
);

  // stage one: magnitudes of the differences
  logic                                s1_valid;
  logic                                s1_cmd;
  logic signed [pnts_pkg::COORD_W-1:0] s1_x, s1_y, s1_z;
  logic                                s1_urgent;
  logic [pnts_pkg::MAG_W-1:0]          s1_mx, s1_mz;

  // stage two: squares
  logic                                s2_valid;
  logic                                s2_cmd;
  logic signed [pnts_pkg::COORD_W-1:0] s2_x, s2_y, s2_z;
  logic                                s2_urgent;
  logic [pnts_pkg::SQ_W-1:0]           s2_sx, s2_sz;

  logic                                advance;
  logic signed [pnts_pkg::COORD_W:0]   dx, dz;
  logic signed [pnts_pkg::COORD_W:0]   ndx, ndz;
  logic [pnts_pkg::MAG_W-1:0]          mx, mz;

  // whole pipeline moves unless the last stage is blocked by a full queue
  assign advance  = !(s2_valid && q_stat.full);
  assign s_tready = advance;

  // signed differences, one bit wider, and their magnitudes
  always_comb begin
    dx  = {s_tdata[20], s_tdata[20:0]} - {cfg.center_x[20], cfg.center_x};
    dz  = {s_tdata[62], s_tdata[62:42]} - {cfg.center_z[20], cfg.center_z};
    ndx = -dx;
    ndz = -dz;
    mx  = dx[pnts_pkg::COORD_W] ? ndx[pnts_pkg::MAG_W-1:0] : dx[pnts_pkg::MAG_W-1:0];
    mz  = dz[pnts_pkg::COORD_W] ? ndz[pnts_pkg::MAG_W-1:0] : dz[pnts_pkg::MAG_W-1:0];
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= s_tvalid;
      s2_valid <= s1_valid;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_cmd    <= s_tuser;
      s1_x      <= s_tdata[20:0];
      s1_y      <= s_tdata[41:21];
      s1_z      <= s_tdata[62:42];
      s1_urgent <= s_tdata[63];
      s1_mx     <= mx;
      s1_mz     <= mz;
      s2_cmd    <= s1_cmd;
      s2_x      <= s1_x;
      s2_y      <= s1_y;
      s2_z      <= s1_z;
      s2_urgent <= s1_urgent;
      s2_sx     <= s1_mx * s1_mx;
      s2_sz     <= s1_mz * s1_mz;
    end
  end

  // sum of squares goes into the queue with the item
  assign q_push = s2_valid && !q_stat.full;
  always_comb begin
    q_data.cmd     = s2_cmd;
    q_data.x       = s2_x;
    q_data.y       = s2_y;
    q_data.z       = s2_z;
    q_data.urgent  = s2_urgent;
    q_data.sq_dist = {1'b0, s2_sx} + {1'b0, s2_sz};
  end

endmodule
`default_nettype wire

### hdl/pnts_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pnts_queue: short item queue between front and back
// Holds classified items with their distances so that the distance pipeline
// and the slot logic stall independently.
// ----------------------------------------------------------------------------
module pnts_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire pnts_pkg::item_t   push_data,
  input  wire logic              pop,
  output pnts_pkg::q_stat_t      stat,
  output pnts_pkg::item_t        head
);

  pnts_pkg::item_t                mem [pnts_pkg::QUEUE_DEPTH];
  logic [pnts_pkg::QPTR_W-1:0]    wr_ptr, rd_ptr;
  logic [pnts_pkg::QCNT_W-1:0]    count;
  logic                           do_push, do_pop;

  assign stat.valid = (count != '0);
  assign stat.full  = (count == pnts_pkg::QCNT_W'(pnts_pkg::QUEUE_DEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && stat.valid;
  assign head       = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

### hdl/pnts_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pnts_back: slot store, replacement search and sorted flush
// Adds offered items while below the limit, otherwise scans the kept slots
// for the worst one and replaces it; a flush repeatedly scans for the best
// remaining slot and sends it through the output register.
// ----------------------------------------------------------------------------
module pnts_back (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic [pnts_pkg::LIMIT_W-1:0]      max_kept,
  input  wire pnts_pkg::q_stat_t                 q_stat,
  input  wire pnts_pkg::item_t                   q_head,
  output logic                                   q_pop,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // m_tdata fields from bit 0: out_x, out_y, out_z, out_urgent, out_dist, zero fill
  output logic [pnts_pkg::M_TDATA_W-1:0]         m_tdata,
  // m_tuser fields from bit 0: set_empty
  output logic                                   m_tuser,
  output logic                                   m_tlast
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_SORT   = 5'b01000,
    ST_PUT    = 5'b10000
  } state_t;

  state_t                          state;
  pnts_pkg::slot_t                 slots [pnts_pkg::MAX_SLOTS];
  logic [pnts_pkg::COUNT_W-1:0]    kept_count;
  logic [pnts_pkg::COUNT_W-1:0]    em_cnt;
  logic [pnts_pkg::SLOT_W-1:0]     scan_idx;
  logic [pnts_pkg::MAX_SLOTS-1:0]  used;
  logic                            have_best;
  logic [pnts_pkg::SLOT_W-1:0]     best_i;
  pnts_pkg::slot_t                 best;
  pnts_pkg::item_t                 cand;
  logic [pnts_pkg::SLOT_W-1:0]     worst_i;
  logic                            worst_u;
  logic [pnts_pkg::DIST_W-1:0]     worst_d;
  logic                            out_valid;
  logic                            out_empty, out_last;
  pnts_pkg::slot_t                 out_slot;

  pnts_pkg::slot_t                 cur;
  logic                            scan_last;
  logic [pnts_pkg::COUNT_W-1:0]    limit;
  logic                            out_free;
  logic                            take;
  logic                            put_last;
  logic                            slot_we;
  logic [pnts_pkg::SLOT_W-1:0]     slot_wi;
  pnts_pkg::slot_t                 slot_wd;
  pnts_pkg::slot_t                 head_slot;

  // effective limit: zero acts as one, large values saturate
  always_comb begin
    if (max_kept == '0) begin
      limit = pnts_pkg::COUNT_W'(1);
    end else if (max_kept > pnts_pkg::LIMIT_W'(pnts_pkg::MAX_SLOTS)) begin
      limit = pnts_pkg::COUNT_W'(pnts_pkg::MAX_SLOTS);
    end else begin
      limit = max_kept[pnts_pkg::COUNT_W-1:0];
    end
  end

  // slot under the scan pointer and end of scan
  assign cur       = slots[scan_idx];
  assign scan_last = (pnts_pkg::COUNT_W'(scan_idx) + pnts_pkg::COUNT_W'(1) == kept_count);
  assign out_free  = !out_valid || m_tready;
  assign put_last  = (em_cnt + pnts_pkg::COUNT_W'(1) == kept_count);
  assign q_pop     = (state == ST_IDLE) && q_stat.valid;

  // replacement rule for the worst slot
  assign take = (cand.urgent || !worst_u) &&
                ((cand.urgent && !worst_u) || (cand.sq_dist < worst_d));

  always_comb begin
    head_slot.x       = q_head.x;
    head_slot.y       = q_head.y;
    head_slot.z       = q_head.z;
    head_slot.urgent  = q_head.urgent;
    head_slot.sq_dist = q_head.sq_dist;
  end

  // slot write port
  always_comb begin
    slot_we = 1'b0;
    slot_wi = kept_count[pnts_pkg::SLOT_W-1:0];
    slot_wd = head_slot;
    if (q_pop && (q_head.cmd == pnts_pkg::CMD_OFFER) && (kept_count < limit)) begin
      slot_we = 1'b1;
    end else if ((state == ST_DECIDE) && take) begin
      slot_we          = 1'b1;
      slot_wi          = worst_i;
      slot_wd.x        = cand.x;
      slot_wd.y        = cand.y;
      slot_wd.z        = cand.z;
      slot_wd.urgent   = cand.urgent;
      slot_wd.sq_dist  = cand.sq_dist;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slots[slot_wi] <= slot_wd;
    end
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      kept_count <= '0;
      em_cnt     <= '0;
      scan_idx   <= '0;
      used       <= '0;
      have_best  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // output register: load on a put, clear once the sink takes it
      if ((state == ST_PUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_pop) begin
            scan_idx <= '0;
            if (q_head.cmd == pnts_pkg::CMD_FLUSH) begin
              em_cnt    <= '0;
              used      <= '0;
              have_best <= 1'b0;
              state     <= (kept_count == '0) ? ST_PUT : ST_SORT;
            end else if (kept_count < limit) begin
              kept_count <= kept_count + 1'b1;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          scan_idx <= scan_idx + 1'b1;
          if (scan_last) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          state <= ST_IDLE;
        end
        ST_SORT: begin
          scan_idx <= scan_idx + 1'b1;
          if (!used[scan_idx] &&
              (!have_best || pnts_pkg::rank_before(cur.urgent, cur.sq_dist,
                                                   best.urgent, best.sq_dist))) begin
            have_best <= 1'b1;
          end
          if (scan_last) begin
            state <= ST_PUT;
          end
        end
        ST_PUT: begin
          if (out_free) begin
            if (kept_count == '0) begin
              state <= ST_IDLE;
            end else begin
              used[best_i] <= 1'b1;
              if (put_last) begin
                kept_count <= '0;
                state      <= ST_IDLE;
              end else begin
                em_cnt    <= em_cnt + 1'b1;
                scan_idx  <= '0;
                have_best <= 1'b0;
                state     <= ST_SORT;
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers: candidate, running worst, running best, output
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cand <= q_head;
    end
    if (state == ST_SCAN) begin
      if ((scan_idx == '0) ||
          pnts_pkg::rank_before(worst_u, worst_d, cur.urgent, cur.sq_dist)) begin
        worst_i <= scan_idx;
        worst_u <= cur.urgent;
        worst_d <= cur.sq_dist;
      end
    end
    if ((state == ST_SORT) && !used[scan_idx] &&
        (!have_best || pnts_pkg::rank_before(cur.urgent, cur.sq_dist,
                                             best.urgent, best.sq_dist))) begin
      best   <= cur;
      best_i <= scan_idx;
    end
    if ((state == ST_PUT) && out_free) begin
      if (kept_count == '0) begin
        out_slot  <= '0;
        out_empty <= 1'b1;
        out_last  <= 1'b1;
      end else begin
        out_slot  <= best;
        out_empty <= 1'b0;
        out_last  <= put_last;
      end
    end
  end

  // output stream
  assign m_tvalid = out_valid;
  assign m_tuser  = out_empty;
  assign m_tlast  = out_last;
  assign m_tdata  = {5'b0, out_slot.sq_dist, out_slot.urgent, out_slot.z, out_slot.y,
                     out_slot.x};

endmodule
`default_nettype wire

### hdl/priority_nearest_top_k_selector_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// priority_nearest_top_k_selector_top: bounded top-k selector for grid points
// Keeps the best entries ranked by priority flag and squared x/z distance
// to a configured centre, and emits them sorted on a flush command.
// ----------------------------------------------------------------------------
// The front end accepts one item per cycle while the queue is not full, and
// computes its distance in a two-stage pipeline (difference and magnitude,
// then a registered square per axis), feeding a four-entry queue. The back
// end takes one item from the queue when idle. An offer that fits below the
// limit is written straight into a slot; an offer into a full set scans the
// kept slots one per cycle. A flush does a selection pass over the kept slots
// per result, or sends a single set_empty result for an empty set. The output
// holds one result in a register, so the back end keeps working while the
// sink stalls for one transfer. Configuration must be written through the
// cfg port only while no item is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module priority_nearest_top_k_selector_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration write port
  input  wire logic                              cfg_wen,
  input  wire logic [1:0]                        cfg_index,
  input  wire logic [pnts_pkg::COORD_W-1:0]      cfg_data,
  // input stream
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // s_tdata fields from bit 0: pos_x, pos_y, pos_z, urgent
  input  wire logic [pnts_pkg::S_TDATA_W-1:0]    s_tdata,
  // s_tuser fields from bit 0: cmd
  input  wire logic                              s_tuser,
  // result stream
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // m_tdata fields from bit 0: out_x, out_y, out_z, out_urgent, out_dist, zero fill
  output logic [pnts_pkg::M_TDATA_W-1:0]         m_tdata,
  // m_tuser fields from bit 0: set_empty
  output logic                                   m_tuser,
  output logic                                   m_tlast
);

  pnts_pkg::cfg_t     cfg;
  pnts_pkg::q_stat_t  q_stat;
  pnts_pkg::item_t    q_in, q_head;
  logic               q_push, q_pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_x <= '0;
      cfg.center_z <= '0;
      cfg.max_kept <= pnts_pkg::MAX_KEPT_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        pnts_pkg::REG_CENTER_X: cfg.center_x <= cfg_data;
        pnts_pkg::REG_CENTER_Z: cfg.center_z <= cfg_data;
        pnts_pkg::REG_MAX_KEPT: cfg.max_kept <= cfg_data[pnts_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  pnts_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  pnts_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .stat      (q_stat),
    .head      (q_head)
  );

  pnts_back u_back (
    .clk      (clk),
    .rst      (rst),
    .max_kept (cfg.max_kept),
    .q_stat   (q_stat),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire

### sim/pnts_order_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnts_order_checker: result checker for the priority nearest top-k selector
// Follows the configuration writes and every transfer on the input stream,
// keeps its own copy of the kept set, predicts the sorted flush output and
// compares every result transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module pnts_order_checker
  import pnts_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_wen,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [COORD_W-1:0]     cfg_data,
  input  wire logic                   s_tvalid,
  input  wire logic                   s_tready,
  input  wire logic [S_TDATA_W-1:0]   s_tdata,
  input  wire logic                   s_tuser,
  input  wire logic                   m_tvalid,
  input  wire logic                   m_tready,
  input  wire logic [M_TDATA_W-1:0]   m_tdata,
  input  wire logic                   m_tuser,
  input  wire logic                   m_tlast,
  output int                          fail_count,
  output int                          pending,
  output int                          results_checked
);

  // bit offsets of the result fields in m_tdata
  localparam int OY_LO   = COORD_W;
  localparam int OZ_LO   = 2 * COORD_W;
  localparam int OU_BIT  = 3 * COORD_W;
  localparam int OD_LO   = 3 * COORD_W + 1;
  localparam int FILL_LO = OD_LO + DIST_W;

  // one kept candidate
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      urgent;
    logic [DIST_W-1:0]         dsq;
  } kept_entry_t;

  // one predicted flush result
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic               urgent;
    logic [DIST_W-1:0]  dsq;
    logic               empty;
    logic               last;
  } sorted_result_t;

  logic signed [COORD_W-1:0] ctr_x;
  logic signed [COORD_W-1:0] ctr_z;
  logic [LIMIT_W-1:0]        keep_limit;
  kept_entry_t               kept_set [MAX_SLOTS];
  int                        kept_n;
  sorted_result_t            sorted_q [$];

  int mismatches  = 0;
  int outstanding = 0;
  int compared    = 0;

  assign fail_count      = mismatches;
  assign pending         = outstanding;
  assign results_checked = compared;

  // strict rank: urgent first, then nearer
  function automatic logic ranks_ahead(input kept_entry_t a, input kept_entry_t b);
    if (a.urgent != b.urgent) begin
      return a.urgent;
    end
    return a.dsq < b.dsq;
  endfunction

  // add the candidate below the limit, else try to displace the worst entry
  task automatic offer_candidate(input logic signed [COORD_W-1:0] x,
                                 input logic signed [COORD_W-1:0] y,
                                 input logic signed [COORD_W-1:0] z,
                                 input logic urgent);
    kept_entry_t cand;
    longint      dx;
    longint      dz;
    int          lim;
    int          worst;
    int          i;
    logic        take;
    dx = longint'(x) - longint'(ctr_x);
    dz = longint'(z) - longint'(ctr_z);
    cand.x      = x;
    cand.y      = y;
    cand.z      = z;
    cand.urgent = urgent;
    cand.dsq    = DIST_W'(dx * dx + dz * dz);
    lim = (keep_limit == 0) ? 1 : int'(keep_limit);
    if (lim > MAX_SLOTS) begin
      lim = MAX_SLOTS;
    end
    if (kept_n < lim) begin
      kept_set[kept_n] = cand;
      kept_n++;
    end else if (kept_n > 0) begin
      worst = 0;
      for (i = 1; i < kept_n; i++) begin
        if (ranks_ahead(kept_set[worst], kept_set[i])) begin
          worst = i;
        end
      end
      if (cand.urgent) begin
        take = !kept_set[worst].urgent || (cand.dsq < kept_set[worst].dsq);
      end else begin
        take = !kept_set[worst].urgent && (cand.dsq < kept_set[worst].dsq);
      end
      if (take) begin
        kept_set[worst] = cand;
      end
    end
  endtask

  // stable sort of the kept set into expected results, then clear it
  task automatic flush_kept_set();
    int             order [MAX_SLOTS];
    int             i;
    int             j;
    int             s;
    sorted_result_t r;
    if (kept_n == 0) begin
      r       = '0;
      r.empty = 1'b1;
      r.last  = 1'b1;
      sorted_q.insert(sorted_q.size(), r);
    end else begin
      for (i = 0; i < kept_n; i++) begin
        s = i;
        j = i;
        while (j > 0 && ranks_ahead(kept_set[s], kept_set[order[j-1]])) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = s;
      end
      for (i = 0; i < kept_n; i++) begin
        s        = order[i];
        r.x      = kept_set[s].x;
        r.y      = kept_set[s].y;
        r.z      = kept_set[s].z;
        r.urgent = kept_set[s].urgent;
        r.dsq    = kept_set[s].dsq;
        r.empty  = 1'b0;
        r.last   = (i == kept_n - 1);
        sorted_q.insert(sorted_q.size(), r);
      end
    end
    kept_n = 0;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // follow config writes and both streams at each rising edge
  always @(posedge clk) begin : track
    sorted_result_t want;
    if (rst) begin
      ctr_x      = '0;
      ctr_z      = '0;
      keep_limit = MAX_KEPT_RESET;
      kept_n     = 0;
      sorted_q.delete();
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          REG_CENTER_X: ctr_x = cfg_data;
          REG_CENTER_Z: ctr_z = cfg_data;
          REG_MAX_KEPT: keep_limit = cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == CMD_FLUSH) begin
          flush_kept_set();
        end else begin
          offer_candidate(s_tdata[COORD_W-1:0], s_tdata[OY_LO +: COORD_W],
                          s_tdata[OZ_LO +: COORD_W], s_tdata[3*COORD_W]);
        end
      end
      if (m_tvalid && m_tready) begin
        if (sorted_q.size() == 0) begin
          mismatches++;
          $display("%0t: result transfer with nothing expected, tdata %0h tuser %b tlast %b",
                   $time, m_tdata, m_tuser, m_tlast);
        end else begin
          want = sorted_q.pop_front();
          compared++;
          check_field("out_x", 64'(want.x), 64'(m_tdata[COORD_W-1:0]));
          check_field("out_y", 64'(want.y), 64'(m_tdata[OY_LO +: COORD_W]));
          check_field("out_z", 64'(want.z), 64'(m_tdata[OZ_LO +: COORD_W]));
          check_field("out_urgent", 64'(want.urgent), 64'(m_tdata[OU_BIT]));
          check_field("out_dist", 64'(want.dsq), 64'(m_tdata[OD_LO +: DIST_W]));
          check_field("tdata fill", 64'(0), 64'(m_tdata[M_TDATA_W-1:FILL_LO]));
          check_field("set_empty", 64'(want.empty), 64'(m_tuser));
          check_field("last", 64'(want.last), 64'(m_tlast));
        end
      end
    end
    outstanding = sorted_q.size();
  end

endmodule

### sim/priority_nearest_top_k_selector_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_nearest_top_k_selector_top_tb: testbench of the top-k selector
// Drives directed and random candidate batches with flushes under changing
// centre and limit settings, with bursty input and a stalling sink; the
// checker beside the block predicts and compares every result transfer.
// ----------------------------------------------------------------------------
module priority_nearest_top_k_selector_top_tb;
  import pnts_pkg::*;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES = 256;
  localparam int RANDOM_ITEMS  = 300;

  localparam logic [COORD_W-1:0] C_MIN = 21'h100000;
  localparam logic [COORD_W-1:0] C_MAX = 21'h0FFFFF;

  logic                   clk;
  logic                   rst;
  logic                   cfg_wen;
  logic [1:0]             cfg_index;
  logic [COORD_W-1:0]     cfg_data;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata;
  logic                   s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [M_TDATA_W-1:0]   m_tdata;
  logic                   m_tuser;
  logic                   m_tlast;

  int fail_count;
  int pending;
  int results_checked;

  int   cycle_count   = 0;
  int   offers_sent   = 0;
  int   flushes_sent  = 0;
  int   cfg_writes    = 0;
  int   burst_left    = 0;
  logic steady_send   = 1'b0;
  int   urgent_pct    = 50;
  int   sink_mode     = 0;
  int   sink_left     = 0;
  int   stall_left    = 0;
  int   sink_tick     = 0;
  logic [COORD_W-1:0] cur_cx = '0;
  logic [COORD_W-1:0] cur_cz = '0;

  priority_nearest_top_k_selector_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  pnts_order_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_wen         (cfg_wen),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .m_tlast         (m_tlast),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("timeout after %0d cycles, %0d results still expected", cycle_count, pending);
    $display("FAILURE");
    $finish;
  end

  // sink stall pattern: always ready, random, stall runs, one in four
  always @(negedge clk) begin : sink_pace
    logic rdy;
    if (sink_left == 0) begin
      sink_mode = $urandom_range(0, 3);
      sink_left = $urandom_range(20, 150);
    end
    sink_left--;
    sink_tick++;
    case (sink_mode)
      0: rdy = 1'b1;
      1: rdy = ($urandom_range(0, 99) < 60);
      2: begin
        if (stall_left > 0) begin
          stall_left--;
          rdy = 1'b0;
        end else begin
          rdy = 1'b1;
          if ($urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 12);
          end
        end
      end
      default: rdy = (sink_tick % 4 == 0);
    endcase
    m_tready <= rdy;
  end

  // sender bursts with gaps in between
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = steady_send ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  // one input transfer; entered and left at a falling edge
  task automatic push(input logic cmd, input logic [COORD_W-1:0] x,
                      input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z,
                      input logic urgent);
    pace();
    s_tvalid <= 1'b1;
    s_tdata  <= {urgent, z, y, x};
    s_tuser  <= cmd;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    if (cmd == CMD_FLUSH) begin
      flushes_sent++;
    end else begin
      offers_sent++;
    end
  endtask

  task automatic offer(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                       input logic [COORD_W-1:0] z, input logic urgent);
    push(CMD_OFFER, x, y, z, urgent);
  endtask

  // payload bits of a flush are don't-care, so send noise there
  task automatic flush();
    push(CMD_FLUSH, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
         1'($urandom));
  endtask

  // drain all expected results, then let offers in flight finish
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // back-to-back register writes, selected by bit: centre x, centre z, limit
  task automatic load_config(input logic [2:0] sel, input logic [COORD_W-1:0] cx,
                             input logic [COORD_W-1:0] cz, input logic [LIMIT_W-1:0] k);
    if (sel[0]) begin
      cfg_wen   <= 1'b1;
      cfg_index <= REG_CENTER_X;
      cfg_data  <= cx;
      cur_cx    = cx;
      cfg_writes++;
      @(negedge clk);
    end
    if (sel[1]) begin
      cfg_wen   <= 1'b1;
      cfg_index <= REG_CENTER_Z;
      cfg_data  <= cz;
      cur_cz    = cz;
      cfg_writes++;
      @(negedge clk);
    end
    if (sel[2]) begin
      cfg_wen   <= 1'b1;
      cfg_index <= REG_MAX_KEPT;
      cfg_data  <= COORD_W'(k);
      cfg_writes++;
      @(negedge clk);
    end
    cfg_wen <= 1'b0;
  endtask

  // coordinate: full range, a few steps around the centre (ties), or an extreme
  function automatic logic [COORD_W-1:0] pick_coord(input logic [COORD_W-1:0] ctr);
    logic [COORD_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = COORD_W'($urandom);
      4, 5, 6, 7: v = ctr + COORD_W'($urandom_range(0, 16)) - COORD_W'(8);
      default: begin
        case ($urandom_range(0, 3))
          0: v = C_MIN;
          1: v = C_MAX;
          2: v = '0;
          default: v = '1;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic logic [COORD_W-1:0] pick_center();
    logic [COORD_W-1:0] v;
    case ($urandom_range(0, 4))
      0: v = C_MIN;
      1: v = C_MAX;
      2: v = '0;
      3: v = COORD_W'($urandom);
      default: v = COORD_W'($urandom_range(0, 200)) - COORD_W'(100);
    endcase
    return v;
  endfunction

  function automatic logic [LIMIT_W-1:0] pick_limit();
    logic [LIMIT_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = 7'd0;
      1: v = 7'd1;
      2: v = 7'd2;
      3: v = 7'(MAX_SLOTS);
      4: v = 7'(MAX_SLOTS + 1);
      5: v = 7'd64;
      6: v = 7'($urandom_range(1, MAX_SLOTS));
      default: v = 7'($urandom_range(0, 64));
    endcase
    return v;
  endfunction

  initial begin : stimulus
    int random_sent;
    int batch;
    int total_fail;
    rst       = 1'b1;
    cfg_wen   = 1'b0;
    cfg_index = REG_CENTER_X;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = CMD_OFFER;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: empty flush, extremes, equal-distance ties
    flush();
    offer(C_MIN, C_MAX, C_MIN, 1'b0);
    offer(C_MAX, C_MIN, C_MAX, 1'b1);
    offer(21'd0, 21'd0, 21'd0, 1'b0);
    offer(21'd3, 21'd7, 21'd4, 1'b0);
    offer(21'd4, '1, 21'd3, 1'b0);
    offer(-21'sd3, 21'd5, -21'sd4, 1'b1);
    offer(-21'sd4, 21'd0, -21'sd3, 1'b0);
    flush();
    settle();

    // limit of zero acts as one: replacement rules on a single slot
    load_config(3'b111, C_MAX, C_MIN, 7'd0);
    offer(21'd0, 21'd1, 21'd0, 1'b0);
    offer(C_MAX, 21'd2, C_MIN + 21'd5, 1'b0);
    offer(C_MIN, 21'd3, C_MAX, 1'b1);
    offer(C_MAX, 21'd4, C_MIN, 1'b0);
    offer(C_MIN, 21'd5, C_MAX, 1'b1);
    offer(C_MAX - 21'd1, 21'd6, C_MIN + 21'd1, 1'b1);
    flush();
    settle();

    // saturated limit, then lowered while holding more than the new limit,
    // with the centre moved so kept distances stay as offered
    load_config(3'b111, C_MIN, C_MAX, 7'd64);
    repeat (6) offer(pick_coord(cur_cx), COORD_W'($urandom), pick_coord(cur_cz),
                     1'($urandom));
    settle();
    load_config(3'b111, 21'd0, C_MAX, 7'd2);
    repeat (3) offer(pick_coord(cur_cx), COORD_W'($urandom), pick_coord(cur_cz),
                     1'($urandom));
    flush();

    // random batches of offers closed by a flush
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      settle();
      if ($urandom_range(0, 2) == 0) begin
        load_config(3'($urandom_range(1, 7)), pick_center(), pick_center(), pick_limit());
      end
      steady_send = ($urandom_range(0, 3) == 0);
      urgent_pct  = $urandom_range(0, 4) * 25;
      batch = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 30);
      repeat (batch) begin
        offer(pick_coord(cur_cx), COORD_W'($urandom), pick_coord(cur_cz),
              ($urandom_range(0, 99) < urgent_pct));
      end
      random_sent += batch;
      // now and then keep the set across a settings change
      if ($urandom_range(0, 5) != 0) begin
        flush();
        random_sent++;
      end
      if ($urandom_range(0, 9) == 0) begin
        flush();
        random_sent++;
      end
    end
    flush();
    settle();

    $display("sent %0d offers and %0d flushes, with %0d register writes between batches",
             offers_sent, flushes_sent, cfg_writes);
    $display("compared %0d sorted results against the predicted order", results_checked);
    total_fail = fail_count + pending;
    if (total_fail == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
hdl/pnts_pkg.sv
hdl/pnts_front.sv
hdl/pnts_queue.sv
hdl/pnts_back.sv
hdl/priority_nearest_top_k_selector_top.sv
sim/pnts_order_checker.sv
sim/priority_nearest_top_k_selector_top_tb.sv
